// File: rtl/core/crr_pkg.sv
// Shared types and constants for the chroma repair and YUV420 to RGB block.
// Depends on nothing; the top level refers to it by scoped names and the testbench imports it.
`timescale 1ns / 1ps
`default_nettype none

package crr_pkg;

	// Largest picture the stores hold.
	localparam int MAX_LW = 1280;
	localparam int MAX_LH = 720;
	localparam int MAX_CW = MAX_LW / 2;
	localparam int MAX_CH = MAX_LH / 2;

	localparam int LUMA_DEPTH   = MAX_LW * MAX_LH;
	localparam int CHROMA_DEPTH = MAX_CW * MAX_CH;
	localparam int ROW_DEPTH    = MAX_CH;

	localparam int LUMA_AW   = $clog2(LUMA_DEPTH);
	localparam int CHROMA_AW = $clog2(CHROMA_DEPTH);
	localparam int ROW_AW    = $clog2(ROW_DEPTH);

	// Command codes.
	localparam logic [1:0] OP_LOAD_CHROMA = 2'd0;
	localparam logic [1:0] OP_LOAD_LUMA   = 2'd1;
	localparam logic [1:0] OP_REPAIR      = 2'd2;
	localparam logic [1:0] OP_FETCH       = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] REG_LUMA_WIDTH    = 3'd0;
	localparam logic [2:0] REG_LUMA_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_CHROMA_WIDTH  = 3'd2;
	localparam logic [2:0] REG_CHROMA_HEIGHT = 3'd3;
	localparam logic [2:0] REG_PITCH_PAD     = 3'd4;

	// Result kinds.
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_PIXEL  = 1'b1;

	// Chroma samples below this on both planes mark a dead pixel.
	localparam logic [7:0] DEAD_LIMIT = 8'd64;
	localparam logic [7:0] NEUTRAL    = 8'd128;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] luma_sample;
		logic [7:0] cb_sample;
		logic [7:0] cr_sample;
	} in_item_t;

	typedef struct packed {
		logic       result_kind;
		logic       frame_dropped;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last_pixel;
	} out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/crr_ram.sv
// Generic single-port synchronous RAM with a registered read.
// Stands alone; used for every store of the chroma repair block.
`timescale 1ns / 1ps
`default_nettype none

module crr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

`default_nettype wire

// File: rtl/core/chroma_repair_yuv420_to_rgb.sv
// Top level of the chroma repair and YUV420 to BT.601 RGB block.
// Depends on crr_pkg for types and constants and on crr_ram for all stores.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one command item when start is high and busy is low, and
// results come back on result for exactly one cycle, marked by strobe; the
// receiver cannot stall them, so it must be ready whenever a result may come.
// Chroma and luma loads make one write into the store per item.
// A fetch passes through address math, two registered multiplies, the memory
// read and two arithmetic stages. The first fetch after reset or after any
// configuration write first runs a one-bit-per-cycle divider, which finds
// the horizontal unwrap and the row and column of the current pixel.
// A repair walks the chroma store once per row, giving dead pixels the last
// good value and filling those in front of the first good pixel (the whole
// row with neutral grey if it has none); it then scores each row, finds the
// nearest good rows above and below, decides for each row and copies the
// rows that need it; the status item comes at its end.
// All work is sequenced over single-port memories, so one item is in flight
// at a time. Configuration may only be written while busy is low.
module chroma_repair_yuv420_to_rgb (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire crr_pkg::in_item_t  cmd,
	output logic                  strobe,
	output crr_pkg::out_item_t    result,
	input  wire logic             wr_en,
	input  wire logic [2:0]       wr_index,
	input  wire logic [10:0]      wr_data
);

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_EXEC   = 5'd1;
	localparam logic [4:0] S_DIV    = 5'd2;
	localparam logic [4:0] S_F_ADDR = 5'd3;
	localparam logic [4:0] S_F_MUL  = 5'd4;
	localparam logic [4:0] S_F_RD   = 5'd5;
	localparam logic [4:0] S_F_MATH = 5'd6;
	localparam logic [4:0] S_F_OUT  = 5'd7;
	localparam logic [4:0] S_R_RD   = 5'd8;
	localparam logic [4:0] S_R_EV   = 5'd9;
	localparam logic [4:0] S_R_END  = 5'd10;
	localparam logic [4:0] S_R_FILL = 5'd11;
	localparam logic [4:0] S_A_RD   = 5'd12;
	localparam logic [4:0] S_A_EV   = 5'd13;
	localparam logic [4:0] S_B_RD   = 5'd14;
	localparam logic [4:0] S_B_EV   = 5'd15;
	localparam logic [4:0] S_C_RD   = 5'd16;
	localparam logic [4:0] S_C_EV   = 5'd17;
	localparam logic [4:0] S_C_MUL  = 5'd18;
	localparam logic [4:0] S_K_RD   = 5'd19;
	localparam logic [4:0] S_K_WR   = 5'd20;
	localparam logic [4:0] S_R_DONE = 5'd21;

	localparam int LAW = crr_pkg::LUMA_AW;
	localparam int CAW = crr_pkg::CHROMA_AW;
	localparam int RAW = crr_pkg::ROW_AW;

	logic [4:0] state_q;
	crr_pkg::in_item_t cmd_q;

	// Configuration registers.
	logic [10:0] lw_q;
	logic [9:0]  lh_q;
	logic [9:0]  cw_q;
	logic [8:0]  ch_q;
	logic [9:0]  pad_q;

	// Sizes saturated into the range the stores cover.
	logic [10:0] lw_e;
	logic [9:0]  lh_e;
	logic [9:0]  cw_e;
	logic [8:0]  ch_e;
	logic [19:0] tot_l_q;
	logic [17:0] tot_c_q;

	// Load and fetch positions.
	logic [17:0] cidx_q;
	logic [19:0] lidx_q;
	logic [17:0] cidx_eff;
	logic [19:0] lidx_eff;
	logic [19:0] pidx_q;
	logic [19:0] pidx_eff;
	logic [10:0] px_x_q;
	logic [9:0]  px_y_q;
	logic [10:0] wrap_q;
	logic        stale_q;

	// Divider.
	logic        div_sel_q;
	logic [4:0]  div_cnt_q;
	logic [19:0] dvd_q;
	logic [10:0] rem_q;
	logic [19:0] quo_q;
	logic [11:0] div_trial;
	logic        div_ge;
	logic [10:0] div_rem;
	logic [19:0] div_quo;

	// Fetch pipeline.
	logic [10:0] sx_s1;
	logic [8:0]  cy_s1;
	logic [9:0]  cx_s1;
	logic [LAW-1:0] laddr_q;
	logic [CAW-1:0] caddr_q;
	logic signed [19:0] ys_s2, re_s2, gd_s2, ge_s2, bd_s2;
	logic [11:0] sx_sum;
	logic [10:0] sx_c;
	logic [9:0]  cx_c;
	logic [8:0]  cy_c;
	logic signed [9:0] c_val, d_val, e_val;
	logic [7:0]  r8, g8, b8, y8;
	logic        greenish;

	// Repair sequencing.
	logic [RAW-1:0] row_q;
	logic [9:0]  x_q;
	logic [CAW-1:0] base_q;
	logic [9:0]  dead_q;
	logic [17:0] dtot_q;
	logic        found_q;
	logic [9:0]  first_x_q;
	logic [15:0] first_val_q;
	logic [15:0] last_q;
	logic [15:0] fill_q;
	logic [9:0]  limit_q;
	logic [RAW-1:0] g_q;
	logic        gv_q;
	logic [RAW-1:0] src_q;
	logic [CAW-1:0] src_base_q;
	logic        pix_dead;
	logic        row_good;
	logic [RAW-1:0] g_new;
	logic        gv_new;

	// Memory ports.
	logic           l_we;
	logic [LAW-1:0] l_addr;
	logic [7:0]     l_rdata;
	logic           c_we;
	logic [CAW-1:0] c_addr;
	logic [15:0]    c_wdata;
	logic [15:0]    c_rdata;
	logic           d_we;
	logic [9:0]     d_rdata;
	logic           a_we;
	logic [9:0]     a_rdata;
	logic           b_we;
	logic [9:0]     b_rdata;

	// Copy source selection.
	logic           a_ok, b_ok;
	logic [RAW-1:0] a_row, b_row, src_c;
	logic           do_copy;

	logic           strobe_q;
	crr_pkg::out_item_t result_q;

	function automatic logic [7:0] clamp_shr8(input logic signed [19:0] v);
		logic signed [19:0] s;
		begin
			s = v >>> 8;
			if (s < 0) begin
				clamp_shr8 = 8'd0;
			end else if (s > 20'sd255) begin
				clamp_shr8 = 8'd255;
			end else begin
				clamp_shr8 = s[7:0];
			end
		end
	endfunction

	always_comb begin
		lw_e = (lw_q < 11'd2) ? 11'd2 :
			(lw_q > 11'(crr_pkg::MAX_LW)) ? 11'(crr_pkg::MAX_LW) : lw_q;
		lh_e = (lh_q < 10'd2) ? 10'd2 :
			(lh_q > 10'(crr_pkg::MAX_LH)) ? 10'(crr_pkg::MAX_LH) : lh_q;
		cw_e = (cw_q < 10'd1) ? 10'd1 :
			(cw_q > 10'(crr_pkg::MAX_CW)) ? 10'(crr_pkg::MAX_CW) : cw_q;
		ch_e = (ch_q < 9'd1) ? 9'd1 :
			(ch_q > 9'(crr_pkg::MAX_CH)) ? 9'(crr_pkg::MAX_CH) : ch_q;
	end

	assign cidx_eff = (cidx_q >= tot_c_q) ? '0 : cidx_q;
	assign lidx_eff = (lidx_q >= tot_l_q) ? '0 : lidx_q;
	assign pidx_eff = (pidx_q >= tot_l_q) ? '0 : pidx_q;
	assign busy = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	// One restoring division step per cycle; the divisor is always the width.
	always_comb begin
		div_trial = {rem_q, dvd_q[19]};
		div_ge = (div_trial >= {1'b0, lw_e});
		div_rem = div_ge ? 11'(div_trial - {1'b0, lw_e}) : div_trial[10:0];
		div_quo = {quo_q[18:0], div_ge};
	end

	// Fetch address math: unwrap the column and clamp into the chroma plane.
	always_comb begin
		sx_sum = {1'b0, px_x_q} + {1'b0, wrap_q};
		sx_c = (sx_sum >= {1'b0, lw_e}) ? 11'(sx_sum - {1'b0, lw_e}) : sx_sum[10:0];
		cx_c = (sx_c[10:1] > (cw_e - 10'd1)) ? (cw_e - 10'd1) : sx_c[10:1];
		cy_c = (px_y_q[9:1] > (ch_e - 9'd1)) ? (ch_e - 9'd1) : px_y_q[9:1];
	end

	// Color arithmetic inputs, the final clamp and the green fault test.
	always_comb begin
		c_val = $signed({2'b00, l_rdata}) - 10'sd16;
		d_val = $signed({2'b00, c_rdata[15:8]}) - 10'sd128;
		e_val = $signed({2'b00, c_rdata[7:0]}) - 10'sd128;
		r8 = clamp_shr8(ys_s2 + re_s2);
		g8 = clamp_shr8(ys_s2 - gd_s2 - ge_s2);
		b8 = clamp_shr8(ys_s2 + bd_s2);
		y8 = clamp_shr8(ys_s2);
		greenish = ({1'b0, g8} > ({1'b0, r8} + 9'd40)) &&
			({1'b0, g8} > ({1'b0, b8} + 9'd40)) &&
			(r8 < 8'd110) && (b8 < 8'd110);
	end

	// Repair helpers.
	always_comb begin
		pix_dead = (c_rdata[15:8] < crr_pkg::DEAD_LIMIT) &&
			(c_rdata[7:0] < crr_pkg::DEAD_LIMIT);
		row_good = (d_rdata <= {2'b00, cw_e[9:2]});
		gv_new = row_good | gv_q;
		g_new = row_good ? row_q : g_q;
		a_ok = a_rdata[9];
		a_row = a_rdata[RAW-1:0];
		b_ok = b_rdata[9];
		b_row = b_rdata[RAW-1:0];
		if (!a_ok) begin
			src_c = b_row;
		end else if (!b_ok) begin
			src_c = a_row;
		end else if ((row_q - a_row) <= (b_row - row_q)) begin
			src_c = a_row;
		end else begin
			src_c = b_row;
		end
		do_copy = (d_rdata > {1'b0, cw_e[9:1]}) && (a_ok || b_ok);
	end

	// Memory port selection.
	always_comb begin
		l_we = (state_q == S_EXEC) && (cmd_q.opcode == crr_pkg::OP_LOAD_LUMA);
		l_addr = l_we ? lidx_eff : laddr_q;
		c_we = 1'b0;
		c_wdata = last_q;
		c_addr = caddr_q;
		case (state_q)
			S_EXEC: begin
				c_addr = cidx_eff;
				c_we = (cmd_q.opcode == crr_pkg::OP_LOAD_CHROMA);
				c_wdata = {cmd_q.cb_sample, cmd_q.cr_sample};
			end
			S_R_RD: begin
				c_addr = base_q + CAW'(x_q);
			end
			S_R_EV: begin
				c_addr = base_q + CAW'(x_q);
				c_we = pix_dead && found_q;
				c_wdata = last_q;
			end
			S_R_FILL: begin
				c_addr = base_q + CAW'(x_q);
				c_we = 1'b1;
				c_wdata = fill_q;
			end
			S_K_RD: begin
				c_addr = src_base_q + CAW'(x_q);
			end
			S_K_WR: begin
				c_addr = base_q + CAW'(x_q);
				c_we = 1'b1;
				c_wdata = c_rdata;
			end
			default: begin
				c_addr = caddr_q;
			end
		endcase
		d_we = (state_q == S_R_END);
		a_we = (state_q == S_A_EV);
		b_we = (state_q == S_B_EV);
	end

	crr_ram #(.WIDTH(8), .DEPTH(crr_pkg::LUMA_DEPTH)) u_luma_ram (
		.clk(clk), .we(l_we), .addr(l_addr), .wdata(cmd_q.luma_sample), .rdata(l_rdata)
	);

	crr_ram #(.WIDTH(16), .DEPTH(crr_pkg::CHROMA_DEPTH)) u_chroma_ram (
		.clk(clk), .we(c_we), .addr(c_addr), .wdata(c_wdata), .rdata(c_rdata)
	);

	crr_ram #(.WIDTH(10), .DEPTH(crr_pkg::ROW_DEPTH)) u_dead_ram (
		.clk(clk), .we(d_we), .addr(row_q), .wdata(dead_q), .rdata(d_rdata)
	);

	crr_ram #(.WIDTH(10), .DEPTH(crr_pkg::ROW_DEPTH)) u_above_ram (
		.clk(clk), .we(a_we), .addr(row_q), .wdata({gv_new, g_new}), .rdata(a_rdata)
	);

	crr_ram #(.WIDTH(10), .DEPTH(crr_pkg::ROW_DEPTH)) u_below_ram (
		.clk(clk), .we(b_we), .addr(row_q), .wdata({gv_new, g_new}), .rdata(b_rdata)
	);

	// Frame sizes are registered products of the saturated registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_l_q <= 20'(crr_pkg::LUMA_DEPTH);
			tot_c_q <= 18'(crr_pkg::CHROMA_DEPTH);
		end else begin
			tot_l_q <= 20'({9'd0, lw_e} * {10'd0, lh_e});
			tot_c_q <= 18'({8'd0, cw_e} * {9'd0, ch_e});
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q <= 11'd1280;
			lh_q <= 10'd720;
			cw_q <= 10'd640;
			ch_q <= 9'd360;
			pad_q <= 10'd128;
		end else if (wr_en) begin
			unique case (wr_index)
				crr_pkg::REG_LUMA_WIDTH:    lw_q <= wr_data;
				crr_pkg::REG_LUMA_HEIGHT:   lh_q <= wr_data[9:0];
				crr_pkg::REG_CHROMA_WIDTH:  cw_q <= wr_data[9:0];
				crr_pkg::REG_CHROMA_HEIGHT: ch_q <= wr_data[8:0];
				crr_pkg::REG_PITCH_PAD:     pad_q <= wr_data[9:0];
				default: begin
				end
			endcase
		end
	end

	// Datapath registers that need no reset.
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q <= cmd;
		end
		if (state_q == S_F_ADDR) begin
			sx_s1 <= sx_c;
			cx_s1 <= cx_c;
			cy_s1 <= cy_c;
		end
		if (state_q == S_F_MUL) begin
			laddr_q <= 20'({10'd0, px_y_q} * {9'd0, lw_e}) + 20'(sx_s1);
			caddr_q <= 18'({9'd0, cy_s1} * {8'd0, cw_e}) + 18'(cx_s1);
		end
		if (state_q == S_F_MATH) begin
			ys_s2 <= c_val * 20'sd298 + 20'sd128;
			re_s2 <= e_val * 20'sd409;
			gd_s2 <= d_val * 20'sd100;
			ge_s2 <= e_val * 20'sd208;
			bd_s2 <= d_val * 20'sd516;
		end
		if (state_q == S_C_MUL) begin
			src_base_q <= 18'({9'd0, src_q} * {8'd0, cw_e});
		end
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cidx_q <= '0;
			lidx_q <= '0;
			pidx_q <= '0;
			px_x_q <= '0;
			px_y_q <= '0;
			wrap_q <= '0;
			stale_q <= 1'b1;
			div_sel_q <= 1'b0;
			div_cnt_q <= '0;
			dvd_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			row_q <= '0;
			x_q <= '0;
			base_q <= '0;
			dead_q <= '0;
			dtot_q <= '0;
			found_q <= 1'b0;
			first_x_q <= '0;
			first_val_q <= '0;
			last_q <= '0;
			fill_q <= '0;
			limit_q <= '0;
			g_q <= '0;
			gv_q <= 1'b0;
			src_q <= '0;
			strobe_q <= 1'b0;
			result_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (wr_en) begin
				stale_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					unique case (cmd_q.opcode)
						crr_pkg::OP_LOAD_CHROMA: begin
							cidx_q <= ({1'b0, cidx_eff} + 19'd1 >= {1'b0, tot_c_q}) ?
								'0 : cidx_eff + 18'd1;
							state_q <= S_IDLE;
						end
						crr_pkg::OP_LOAD_LUMA: begin
							lidx_q <= ({1'b0, lidx_eff} + 21'd1 >= {1'b0, tot_l_q}) ?
								'0 : lidx_eff + 20'd1;
							state_q <= S_IDLE;
						end
						crr_pkg::OP_REPAIR: begin
							row_q <= '0;
							base_q <= '0;
							x_q <= '0;
							dead_q <= '0;
							dtot_q <= '0;
							found_q <= 1'b0;
							state_q <= S_R_RD;
						end
						crr_pkg::OP_FETCH: begin
							if (stale_q) begin
								// First find the unwrap shift, then the pixel position.
								div_sel_q <= 1'b0;
								div_cnt_q <= '0;
								dvd_q <= {9'd0, pad_q, 1'b0};
								rem_q <= '0;
								quo_q <= '0;
								state_q <= S_DIV;
							end else begin
								state_q <= S_F_ADDR;
							end
						end
						default: begin
							state_q <= S_IDLE;
						end
					endcase
				end
				S_DIV: begin
					dvd_q <= {dvd_q[18:0], 1'b0};
					rem_q <= div_rem;
					quo_q <= div_quo;
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd19) begin
						if (!div_sel_q) begin
							wrap_q <= div_rem;
							div_sel_q <= 1'b1;
							div_cnt_q <= '0;
							dvd_q <= pidx_eff;
							rem_q <= '0;
							quo_q <= '0;
						end else begin
							pidx_q <= pidx_eff;
							px_x_q <= div_rem;
							px_y_q <= div_quo[9:0];
							stale_q <= 1'b0;
							state_q <= S_F_ADDR;
						end
					end
				end
				S_F_ADDR: state_q <= S_F_MUL;
				S_F_MUL:  state_q <= S_F_RD;
				S_F_RD:   state_q <= S_F_MATH;
				S_F_MATH: state_q <= S_F_OUT;
				S_F_OUT: begin
					strobe_q <= 1'b1;
					result_q.result_kind <= crr_pkg::KIND_PIXEL;
					result_q.frame_dropped <= 1'b0;
					result_q.red <= greenish ? y8 : r8;
					result_q.green <= greenish ? y8 : g8;
					result_q.blue <= greenish ? y8 : b8;
					result_q.last_pixel <= (pidx_q == (tot_l_q - 20'd1));
					if ({1'b0, pidx_q} + 21'd1 >= {1'b0, tot_l_q}) begin
						pidx_q <= '0;
						px_x_q <= '0;
						px_y_q <= '0;
					end else begin
						pidx_q <= pidx_q + 20'd1;
						if (px_x_q + 11'd1 == lw_e) begin
							px_x_q <= '0;
							px_y_q <= px_y_q + 10'd1;
						end else begin
							px_x_q <= px_x_q + 11'd1;
						end
					end
					state_q <= S_IDLE;
				end
				S_R_RD: state_q <= S_R_EV;
				S_R_EV: begin
					// Dead pixels after the first good one take the last good value.
					if (pix_dead) begin
						dead_q <= dead_q + 10'd1;
					end else begin
						last_q <= c_rdata;
						if (!found_q) begin
							found_q <= 1'b1;
							first_x_q <= x_q;
							first_val_q <= c_rdata;
						end
					end
					if (x_q + 10'd1 == cw_e) begin
						state_q <= S_R_END;
					end else begin
						x_q <= x_q + 10'd1;
						state_q <= S_R_RD;
					end
				end
				S_R_END: begin
					dtot_q <= dtot_q + 18'(dead_q);
					x_q <= '0;
					if (found_q) begin
						fill_q <= first_val_q;
						limit_q <= first_x_q;
					end else begin
						fill_q <= {crr_pkg::NEUTRAL, crr_pkg::NEUTRAL};
						limit_q <= cw_e;
					end
					if (found_q && (first_x_q == 10'd0)) begin
						if ({1'b0, row_q} + 10'd1 == {1'b0, ch_e}) begin
							row_q <= '0;
							g_q <= '0;
							gv_q <= 1'b0;
							state_q <= S_A_RD;
						end else begin
							row_q <= row_q + 9'd1;
							base_q <= base_q + 18'(cw_e);
							dead_q <= '0;
							found_q <= 1'b0;
							state_q <= S_R_RD;
						end
					end else begin
						state_q <= S_R_FILL;
					end
				end
				S_R_FILL: begin
					if (x_q + 10'd1 == limit_q) begin
						x_q <= '0;
						if ({1'b0, row_q} + 10'd1 == {1'b0, ch_e}) begin
							row_q <= '0;
							g_q <= '0;
							gv_q <= 1'b0;
							state_q <= S_A_RD;
						end else begin
							row_q <= row_q + 9'd1;
							base_q <= base_q + 18'(cw_e);
							dead_q <= '0;
							found_q <= 1'b0;
							state_q <= S_R_RD;
						end
					end else begin
						x_q <= x_q + 10'd1;
					end
				end
				S_A_RD: state_q <= S_A_EV;
				S_A_EV: begin
					g_q <= g_new;
					gv_q <= gv_new;
					if ({1'b0, row_q} + 10'd1 == {1'b0, ch_e}) begin
						g_q <= '0;
						gv_q <= 1'b0;
						state_q <= S_B_RD;
					end else begin
						row_q <= row_q + 9'd1;
						state_q <= S_A_RD;
					end
				end
				S_B_RD: state_q <= S_B_EV;
				S_B_EV: begin
					g_q <= g_new;
					gv_q <= gv_new;
					if (row_q == '0) begin
						base_q <= '0;
						state_q <= S_C_RD;
					end else begin
						row_q <= row_q - 9'd1;
						state_q <= S_B_RD;
					end
				end
				S_C_RD: state_q <= S_C_EV;
				S_C_EV: begin
					if (do_copy) begin
						src_q <= src_c;
						state_q <= S_C_MUL;
					end else if ({1'b0, row_q} + 10'd1 == {1'b0, ch_e}) begin
						state_q <= S_R_DONE;
					end else begin
						row_q <= row_q + 9'd1;
						base_q <= base_q + 18'(cw_e);
						state_q <= S_C_RD;
					end
				end
				S_C_MUL: begin
					x_q <= '0;
					state_q <= S_K_RD;
				end
				S_K_RD: state_q <= S_K_WR;
				S_K_WR: begin
					if (x_q + 10'd1 == cw_e) begin
						x_q <= '0;
						if ({1'b0, row_q} + 10'd1 == {1'b0, ch_e}) begin
							state_q <= S_R_DONE;
						end else begin
							row_q <= row_q + 9'd1;
							base_q <= base_q + 18'(cw_e);
							state_q <= S_C_RD;
						end
					end else begin
						x_q <= x_q + 10'd1;
						state_q <= S_K_RD;
					end
				end
				S_R_DONE: begin
					strobe_q <= 1'b1;
					result_q.result_kind <= crr_pkg::KIND_STATUS;
					result_q.frame_dropped <= (dtot_q > {1'b0, tot_c_q[17:1]});
					result_q.red <= '0;
					result_q.green <= '0;
					result_q.blue <= '0;
					result_q.last_pixel <= 1'b0;
					cidx_q <= '0;
					lidx_q <= '0;
					pidx_q <= '0;
					px_x_q <= '0;
					px_y_q <= '0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: tb/sv/tb_chroma_repair_yuv420_to_rgb.sv
// Self-checking testbench for chroma_repair_yuv420_to_rgb: loads small frames,
// repairs them and fetches RGB pixels, checking each against its own predictor.
// Depends on crr_pkg for the command and result types and all code constants.
`timescale 1ns / 1ps

module tb_chroma_repair_yuv420_to_rgb;
	import crr_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	// Quiet cycles after the last result, counted while the block is idle.
	localparam int SETTLE_CYCLES = 80;

	typedef enum logic [1:0] {
		STEP_CMD,
		STEP_CFG,
		STEP_DRAIN,
		STEP_IDLE_MODE
	} step_kind_e;

	typedef struct {
		step_kind_e kind;
		in_item_t   cmd;
		logic [2:0] index;
		logic [10:0] data;
	} step_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	in_item_t cmd = '0;
	logic strobe;
	out_item_t result;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = '0;
	logic [10:0] wr_data = '0;

	chroma_repair_yuv420_to_rgb dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.strobe(strobe),
		.result(result),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	always #5 clk = ~clk;

	// Stimulus queue that the driver consumes, and the results still awaited.
	step_t     stimulus[$];
	out_item_t awaited_results[$];

	int errors = 0;
	int cycles = 0;
	int n_items = 0;
	int n_pixels = 0;
	int n_repairs = 0;
	int n_dropped = 0;
	int n_cfg = 0;

	// ------------------------------------------------------------------
	// Predictor state: its own copy of the planes, registers and counters.
	// ------------------------------------------------------------------
	logic [7:0] luma_plane [LUMA_DEPTH];
	logic [7:0] cb_plane [CHROMA_DEPTH];
	logic [7:0] cr_plane [CHROMA_DEPTH];
	int lw_reg = 1280, lh_reg = 720, cw_reg = 640, ch_reg = 360, pad_reg = 128;
	int chroma_wr_pos = 0, luma_wr_pos = 0, pixel_pos = 0;

	function automatic int clip(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int byte_sat(int v);
		// Arithmetic shift gives floor division by 256 for negative sums too.
		return clip(v >>> 8, 0, 255);
	endfunction

	function automatic void apply_register(logic [2:0] idx, logic [10:0] val);
		case (idx)
			REG_LUMA_WIDTH:    lw_reg = int'(val);
			REG_LUMA_HEIGHT:   lh_reg = int'(val[9:0]);
			REG_CHROMA_WIDTH:  cw_reg = int'(val[9:0]);
			REG_CHROMA_HEIGHT: ch_reg = int'(val[8:0]);
			REG_PITCH_PAD:     pad_reg = int'(val[9:0]);
			default: ;
		endcase
	endfunction

	// Fills dead chroma along each row, then replaces mostly dead rows with
	// the nearest mostly good row. Returns the dropped-frame flag.
	function automatic bit repair_planes();
		int cw, ch, first, last, dead, dead_sum, src, g;
		bit gv;
		int row_dead [MAX_CH];
		int up_row [MAX_CH];
		int dn_row [MAX_CH];
		bit up_ok [MAX_CH];
		bit dn_ok [MAX_CH];
		cw = clip(cw_reg, 1, MAX_CW);
		ch = clip(ch_reg, 1, MAX_CH);
		dead_sum = 0;
		for (int r = 0; r < ch; r++) begin
			first = cw;
			dead = 0;
			for (int x = 0; x < cw; x++) begin
				if (!(cb_plane[r*cw+x] < DEAD_LIMIT && cr_plane[r*cw+x] < DEAD_LIMIT)) begin
					first = x;
					break;
				end
			end
			if (first == cw) begin
				// No good pixel anywhere in the row: neutral grey chroma.
				for (int x = 0; x < cw; x++) begin
					cb_plane[r*cw+x] = NEUTRAL;
					cr_plane[r*cw+x] = NEUTRAL;
				end
				row_dead[r] = cw;
				dead_sum += cw;
				continue;
			end
			for (int x = 0; x < first; x++) begin
				cb_plane[r*cw+x] = cb_plane[r*cw+first];
				cr_plane[r*cw+x] = cr_plane[r*cw+first];
				dead++;
			end
			last = first;
			for (int x = first; x < cw; x++) begin
				if (!(cb_plane[r*cw+x] < DEAD_LIMIT && cr_plane[r*cw+x] < DEAD_LIMIT)) begin
					last = x;
				end else begin
					cb_plane[r*cw+x] = cb_plane[r*cw+last];
					cr_plane[r*cw+x] = cr_plane[r*cw+last];
					dead++;
				end
			end
			row_dead[r] = dead;
			dead_sum += dead;
		end
		g = 0;
		gv = 1'b0;
		for (int r = 0; r < ch; r++) begin
			if (row_dead[r] <= cw / 4) begin
				g = r;
				gv = 1'b1;
			end
			up_row[r] = g;
			up_ok[r] = gv;
		end
		g = 0;
		gv = 1'b0;
		for (int r = ch - 1; r >= 0; r--) begin
			if (row_dead[r] <= cw / 4) begin
				g = r;
				gv = 1'b1;
			end
			dn_row[r] = g;
			dn_ok[r] = gv;
		end
		for (int r = 0; r < ch; r++) begin
			if (row_dead[r] <= cw / 2 || (!up_ok[r] && !dn_ok[r]))
				continue;
			if (!up_ok[r])
				src = dn_row[r];
			else if (!dn_ok[r])
				src = up_row[r];
			else
				src = (r - up_row[r] <= dn_row[r] - r) ? up_row[r] : dn_row[r];
			for (int x = 0; x < cw; x++) begin
				cb_plane[r*cw+x] = cb_plane[src*cw+x];
				cr_plane[r*cw+x] = cr_plane[src*cw+x];
			end
		end
		chroma_wr_pos = 0;
		luma_wr_pos = 0;
		pixel_pos = 0;
		return dead_sum > (cw * ch) / 2;
	endfunction

	function automatic out_item_t convert_next_pixel();
		int w, h, cw, ch, total, idx, x, y, sx, cx, cy, ci, c, d, e, rr, gg, bb;
		out_item_t px;
		w = clip(lw_reg, 2, MAX_LW);
		h = clip(lh_reg, 2, MAX_LH);
		cw = clip(cw_reg, 1, MAX_CW);
		ch = clip(ch_reg, 1, MAX_CH);
		total = w * h;
		idx = (pixel_pos >= total) ? 0 : pixel_pos;
		y = idx / w;
		x = idx % w;
		sx = (x + (pad_reg * 2) % w) % w;
		cx = clip(sx >> 1, 0, cw - 1);
		cy = clip(y >> 1, 0, ch - 1);
		ci = cy * cw + cx;
		c = int'(luma_plane[y*w+sx]) - 16;
		d = int'(cb_plane[ci]) - 128;
		e = int'(cr_plane[ci]) - 128;
		rr = byte_sat(298*c + 409*e + 128);
		gg = byte_sat(298*c - 100*d - 208*e + 128);
		bb = byte_sat(298*c + 516*d + 128);
		// Strong green with weak red and blue is taken as a decode fault.
		if (gg > rr + 40 && gg > bb + 40 && rr < 110 && bb < 110) begin
			rr = byte_sat(298*c + 128);
			gg = rr;
			bb = rr;
		end
		px = '0;
		px.result_kind = KIND_PIXEL;
		px.red = rr[7:0];
		px.green = gg[7:0];
		px.blue = bb[7:0];
		px.last_pixel = (idx == total - 1);
		pixel_pos = (idx + 1 >= total) ? 0 : idx + 1;
		return px;
	endfunction

	// Advances the predictor by one accepted item and queues its result, if it has one.
	function automatic void predict_item(in_item_t it);
		int total;
		out_item_t st;
		case (it.opcode)
			OP_LOAD_CHROMA: begin
				total = clip(cw_reg, 1, MAX_CW) * clip(ch_reg, 1, MAX_CH);
				if (chroma_wr_pos >= total)
					chroma_wr_pos = 0;
				cb_plane[chroma_wr_pos] = it.cb_sample;
				cr_plane[chroma_wr_pos] = it.cr_sample;
				chroma_wr_pos = (chroma_wr_pos + 1 >= total) ? 0 : chroma_wr_pos + 1;
			end
			OP_LOAD_LUMA: begin
				total = clip(lw_reg, 2, MAX_LW) * clip(lh_reg, 2, MAX_LH);
				if (luma_wr_pos >= total)
					luma_wr_pos = 0;
				luma_plane[luma_wr_pos] = it.luma_sample;
				luma_wr_pos = (luma_wr_pos + 1 >= total) ? 0 : luma_wr_pos + 1;
			end
			OP_REPAIR: begin
				st = '0;
				st.result_kind = KIND_STATUS;
				st.frame_dropped = repair_planes();
				awaited_results.push_back(st);
				n_repairs++;
				if (st.frame_dropped)
					n_dropped++;
			end
			default: begin
				awaited_results.push_back(convert_next_pixel());
				n_pixels++;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Stimulus building.
	// ------------------------------------------------------------------
	function automatic in_item_t make_item(logic [1:0] op, int y, int cb, int cr);
		in_item_t it;
		it.opcode = op;
		it.luma_sample = y[7:0];
		it.cb_sample = cb[7:0];
		it.cr_sample = cr[7:0];
		return it;
	endfunction

	function automatic void push_item(in_item_t it);
		step_t s;
		s.kind = STEP_CMD;
		s.cmd = it;
		s.index = '0;
		s.data = '0;
		stimulus.push_back(s);
	endfunction

	function automatic void push_control(step_kind_e k, logic [2:0] idx, logic [10:0] val);
		step_t s;
		s.kind = k;
		s.cmd = '0;
		s.index = idx;
		s.data = val;
		stimulus.push_back(s);
	endfunction

	// A configuration change always follows a drain so the block is idle.
	function automatic void push_config(int lw, int lh, int cw, int ch, int pad);
		push_control(STEP_DRAIN, '0, '0);
		push_control(STEP_CFG, REG_LUMA_WIDTH, lw[10:0]);
		push_control(STEP_CFG, REG_LUMA_HEIGHT, lh[10:0]);
		push_control(STEP_CFG, REG_CHROMA_WIDTH, cw[10:0]);
		push_control(STEP_CFG, REG_CHROMA_HEIGHT, ch[10:0]);
		push_control(STEP_CFG, REG_PITCH_PAD, pad[10:0]);
	endfunction

	// A chroma pair that is dead (both below the limit) or good, with some
	// good pairs kept low so that strongly green pixels appear.
	function automatic in_item_t random_chroma(bit dead);
		int cb, cr;
		if (dead) begin
			cb = $urandom_range(63);
			cr = $urandom_range(63);
		end else if ($urandom_range(7) == 0) begin
			cb = $urandom_range(100, 64);
			cr = $urandom_range(100, 40);
		end else begin
			cb = $urandom_range(255);
			cr = (cb < 64) ? $urandom_range(255, 64) : $urandom_range(255);
		end
		return make_item(OP_LOAD_CHROMA, $urandom_range(255), cb, cr);
	endfunction

	// One full frame: every chroma and luma entry is written (the counters
	// wrap, so a full run covers every entry wherever it starts), then a
	// repair, then a stretch of fetches with some random items mixed in.
	function automatic void push_frame(int w, int h, int cw, int ch, bit fixed_rows);
		in_item_t chroma_items[$];
		int row_pct, luma_left, fetches;
		int pct_choice [4] = '{0, 100, 70, 30};
		for (int r = 0; r < ch; r++) begin
			row_pct = fixed_rows ? pct_choice[r % 4] : pct_choice[$urandom_range(3)];
			for (int x = 0; x < cw; x++)
				chroma_items.push_back(random_chroma($urandom_range(99) < row_pct));
		end
		luma_left = w * h;
		while (chroma_items.size() > 0 || luma_left > 0) begin
			if (luma_left == 0 || (chroma_items.size() > 0 && $urandom_range(3) == 0)) begin
				push_item(chroma_items.pop_front());
			end else begin
				push_item(make_item(OP_LOAD_LUMA, $urandom_range(255),
					$urandom_range(255), $urandom_range(255)));
				luma_left--;
			end
		end
		push_item(make_item(OP_REPAIR, $urandom_range(255), $urandom_range(255),
			$urandom_range(255)));
		fetches = $urandom_range(w * h + 4, (w * h) / 2);
		for (int i = 0; i < fetches; i++) begin
			if ($urandom_range(9) == 0)
				push_item(make_item($urandom_range(3), $urandom_range(255),
					$urandom_range(255), $urandom_range(255)));
			else
				push_item(make_item(OP_FETCH, $urandom_range(255), $urandom_range(255),
					$urandom_range(255)));
		end
	endfunction

	// ------------------------------------------------------------------
	// Driver: changes inputs on the falling edge, one item at a time.
	// ------------------------------------------------------------------
	logic taken = 1'b0;
	int drain_left = 0;
	int idle_pct = 0;

	always @(negedge clk) begin : driver
		step_t s;
		if (!arst_n || (start && !taken)) begin
			// In reset, or an item is still waiting to be accepted.
		end else if (drain_left > 0) begin
			start <= 1'b0;
			wr_en <= 1'b0;
			if (awaited_results.size() == 0 && !busy)
				drain_left <= drain_left - 1;
		end else if (stimulus.size() == 0 || (idle_pct > 0 && $urandom_range(99) < idle_pct)) begin
			start <= 1'b0;
			wr_en <= 1'b0;
		end else begin
			s = stimulus.pop_front();
			case (s.kind)
				STEP_CMD: begin
					start <= 1'b1;
					cmd <= s.cmd;
					wr_en <= 1'b0;
				end
				STEP_CFG: begin
					start <= 1'b0;
					wr_en <= 1'b1;
					wr_index <= s.index;
					wr_data <= s.data;
				end
				STEP_DRAIN: begin
					start <= 1'b0;
					wr_en <= 1'b0;
					drain_left <= SETTLE_CYCLES;
				end
				default: begin
					start <= 1'b0;
					wr_en <= 1'b0;
					idle_pct <= int'(s.data);
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Monitor: samples at the rising edge, checks results, feeds predictor.
	// ------------------------------------------------------------------
	task automatic report_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	always @(posedge clk) begin : monitor
		out_item_t exp_r;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("tb_chroma_repair_yuv420_to_rgb failed");
			$finish;
		end else if (arst_n) begin
			taken <= start && !busy;
			if (strobe) begin
				if (awaited_results.size() == 0) begin
					$error("result with no item awaiting it");
					errors++;
				end else begin
					exp_r = awaited_results.pop_front();
					report_field("result_kind", exp_r.result_kind, result.result_kind);
					report_field("frame_dropped", exp_r.frame_dropped, result.frame_dropped);
					report_field("red", exp_r.red, result.red);
					report_field("green", exp_r.green, result.green);
					report_field("blue", exp_r.blue, result.blue);
					report_field("last_pixel", exp_r.last_pixel, result.last_pixel);
				end
			end
			if (wr_en) begin
				apply_register(wr_index, wr_data);
				n_cfg++;
			end
			if (start && !busy) begin
				predict_item(cmd);
				n_items++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------
	initial begin
		// Directed part: every register at zero gives the smallest frame, a
		// 2x2 picture over a single chroma pixel. A dead pixel fills the row
		// with neutral grey and drops the frame; luma extremes saturate.
		push_config(0, 0, 0, 0, 0);
		push_item(make_item(OP_LOAD_CHROMA, 0, 0, 0));
		push_item(make_item(OP_LOAD_LUMA, 0, 0, 0));
		push_item(make_item(OP_LOAD_LUMA, 255, 0, 0));
		push_item(make_item(OP_LOAD_LUMA, 16, 0, 0));
		push_item(make_item(OP_LOAD_LUMA, 235, 0, 0));
		push_item(make_item(OP_REPAIR, 0, 0, 0));
		for (int i = 0; i < 5; i++)
			push_item(make_item(OP_FETCH, 0, 0, 0));
		// Saturated colors, then a low chroma pair that reads as strong green.
		push_item(make_item(OP_LOAD_CHROMA, 255, 255, 255));
		push_item(make_item(OP_REPAIR, 255, 255, 255));
		push_item(make_item(OP_FETCH, 255, 255, 255));
		push_item(make_item(OP_FETCH, 255, 255, 255));
		push_item(make_item(OP_LOAD_CHROMA, 0, 70, 70));
		push_item(make_item(OP_LOAD_LUMA, 180, 0, 0));
		push_item(make_item(OP_REPAIR, 0, 0, 0));
		push_item(make_item(OP_FETCH, 0, 0, 0));
		push_item(make_item(OP_FETCH, 0, 0, 0));

		// Largest pad, then chroma narrower than half the luma so the chroma
		// coordinate saturates. Row patterns here are fixed: good, fully
		// dead, mostly dead, partly dead.
		push_config(12, 6, 6, 3, 1023);
		push_frame(12, 6, 6, 3, 1'b1);
		push_config(10, 8, 3, 2, 5);
		push_frame(10, 8, 3, 2, 1'b1);

		// Every register at its largest raw value: loads only, since a
		// repair or fetch would read entries that were never written.
		push_config(2047, 1023, 1023, 511, 1023);
		for (int i = 0; i < 20; i++)
			push_item(make_item($urandom_range(1), $urandom_range(255),
				$urandom_range(255), $urandom_range(255)));

		// Random part over several idling patterns. A drain between some frames
		// makes the sender wait until every awaited result has come.
		push_config(12, 8, 6, 4, 3);
		push_control(STEP_IDLE_MODE, '0, 11'd80);
		push_frame(12, 8, 6, 4, 1'b0);
		push_control(STEP_DRAIN, '0, '0);
		push_control(STEP_IDLE_MODE, '0, 11'd28);
		push_frame(12, 8, 6, 4, 1'b0);
		push_control(STEP_IDLE_MODE, '0, 11'd0);
		push_frame(12, 8, 6, 4, 1'b0);
		push_config(7, 5, 4, 3, 2);
		push_control(STEP_IDLE_MODE, '0, 11'd28);
		push_frame(7, 5, 4, 3, 1'b0);
		push_frame(7, 5, 4, 3, 1'b0);
		push_control(STEP_DRAIN, '0, '0);

		// Single reset at the start, released on a falling edge.
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// The final drain waits for the last result and then the settle time.
		@(posedge clk);
		while (stimulus.size() > 0 || drain_left > 0 || start)
			@(posedge clk);
		if (awaited_results.size() != 0) begin
			$error("%0d results never arrived", awaited_results.size());
			errors++;
		end
		$display("covered %0d items with %0d register writes: %0d repairs (%0d dropped),",
			n_items, n_cfg, n_repairs, n_dropped);
		$display("%0d converted pixels, in %0d cycles", n_pixels, cycles);
		if (errors == 0)
			$display("tb_chroma_repair_yuv420_to_rgb passed");
		else
			$display("tb_chroma_repair_yuv420_to_rgb failed");
		$finish;
	end

endmodule
